// ===== rtl/pidc_pkg.sv =====
package pidc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ERROR_DEADBAND = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_MIN      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_MAX      = 3'd6;

    localparam int DIV_W     = 32;
    localparam int DIVISOR_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int RCP_W      = 33;
    localparam int HALF_W     = 16;
    localparam int RCP_PART_W = HALF_W + RCP_W;
    localparam int RCP_SUM_W  = DIV_W + RCP_W;

    localparam int ERR_W   = 17;
    localparam int INTEG_W = 21;
    localparam int DERIV_W = 18;
    localparam int MUL_A_W = 21;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = 40;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ED,
        ST_QUO_LO,
        ST_QUO_HI,
        ST_ACC,
        ST_DIV_D,
        ST_WAIT_D,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_SUM_D,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_MUL_ED,
        OP_QUO_LO,
        OP_QUO_HI,
        OP_ACC,
        OP_DIV_D,
        OP_DERIV,
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_D,
        OP_SUM_D,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/pid_controller_step_core.sv =====
// An update request steps through MUL_ED, QUO_LO, QUO_HI, ACC, DIV_D, WAIT_D, MUL_P, MUL_I,
//   MUL_D, SUM_D and DONE before m_axis_tvalid; a clear goes straight to DONE. No new request
//   is taken until DONE; WAIT_D waits on the 32-step shift-subtract division by elapsed.
// A finished result waits in the output register while the next request is accepted.
// Reset (rst_n low, asynchronous): integral and previous error cleared, gains zero,
//   drive limits at full range, no result pending.
module pid_controller_step_core #(
    parameter int INTEGRAL_SCALE = 40
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [47:0]                          s_axis_tdata,  // target, measurement, elapsed
    input  logic [0:0]                           s_axis_tuser,  // clear_state
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [15:0]                          m_axis_tdata,  // drive
    output logic [0:0]                           m_axis_tuser,  // elapsed_zero
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pidc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pidc_pkg::cmd_t    cmd;
    pidc_pkg::stat_t   stat;
    logic signed [15:0] drive;
    logic               elapsed_zero;

    pidc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_clear (s_axis_tuser[0]),
        .stat     (stat),
        .cmd      (cmd)
    );

    pidc_datapath #(
        .INTEGRAL_SCALE (INTEGRAL_SCALE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .target       (s_axis_tdata[15:0]),
        .measurement  (s_axis_tdata[31:16]),
        .elapsed      (s_axis_tdata[47:32]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .drive        (drive),
        .elapsed_zero (elapsed_zero)
    );

    assign cfg_ready       = 1'b1;
    assign m_axis_tdata    = drive;
    assign m_axis_tuser[0] = elapsed_zero;

endmodule

// ===== rtl/pidc_div.sv =====
module pidc_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [pidc_pkg::DIV_W-1:0]         dividend,
    input  logic [pidc_pkg::DIVISOR_W-1:0]     divisor,
    output logic                               done,
    output logic [pidc_pkg::DIV_W-1:0]         quotient
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [pidc_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [pidc_pkg::DIV_W-1:0]          quo_reg, quo_next;
    logic [pidc_pkg::DIVISOR_W-1:0]      rem_reg, rem_next;
    logic [pidc_pkg::DIVISOR_W-1:0]      dvs_reg, dvs_next;
    logic [pidc_pkg::DIVISOR_W:0]        trial;
    logic                                ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[pidc_pkg::DIV_W-1]};
        ge        = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? pidc_pkg::DIVISOR_W'(trial - {1'b0, dvs_reg})
                          : trial[pidc_pkg::DIVISOR_W-1:0];
            quo_next = {quo_reg[pidc_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pidc_pkg::DIV_CNT_W'(pidc_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/pidc_datapath.sv =====
module pidc_datapath #(
    parameter int INTEGRAL_SCALE = 40
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pidc_pkg::cmd_t                       cmd,
    output pidc_pkg::stat_t                      stat,
    input  logic                                 cfg_valid,
    input  logic [pidc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [15:0]                   target,
    input  logic signed [15:0]                   measurement,
    input  logic [15:0]                          elapsed,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [15:0]                   drive,
    output logic                                 elapsed_zero
);

    localparam int ACC_W = 34;

    // Reciprocal of the integral scale, exact for any 32-bit dividend
    localparam int SCALE_LOG = $clog2(INTEGRAL_SCALE);
    localparam int RCP_SHIFT = pidc_pkg::DIV_W + SCALE_LOG;
    localparam logic [63:0] RCP_FULL = ((64'd1 << RCP_SHIFT) + 64'(INTEGRAL_SCALE) - 64'd1)
                                       / 64'(INTEGRAL_SCALE);
    localparam logic [pidc_pkg::RCP_W-1:0] RCP_MUL = pidc_pkg::RCP_W'(RCP_FULL);

    logic signed [15:0]                      prop_gain_reg;
    logic signed [15:0]                      integ_gain_reg;
    logic signed [15:0]                      deriv_gain_reg;
    logic [19:0]                             integral_limit_reg;
    logic [16:0]                             error_deadband_reg;
    logic signed [15:0]                      drive_min_reg;
    logic signed [15:0]                      drive_max_reg;

    logic signed [pidc_pkg::ERR_W-1:0]       err_reg, last_reg;
    logic [15:0]                             dt_reg;
    logic                                    zflag_reg, clr_reg, neg_reg;
    logic signed [pidc_pkg::INTEG_W-1:0]     integ_reg;
    logic signed [pidc_pkg::DERIV_W-1:0]     deriv_reg;
    logic signed [pidc_pkg::PROD_W-1:0]      prod_reg;
    logic signed [pidc_pkg::SUM_W-1:0]       sum_reg;
    logic                                    out_valid_reg;
    logic signed [15:0]                      drive_reg;
    logic                                    ezero_reg;
    logic [pidc_pkg::RCP_PART_W-1:0]         rcp_lo_reg;
    logic [pidc_pkg::DIV_W-1:0]              iquo_reg;

    logic                                    div_start, div_done;
    logic [pidc_pkg::DIV_W-1:0]              div_dividend, div_quotient;
    logic [pidc_pkg::DIVISOR_W-1:0]          div_divisor;

    logic signed [pidc_pkg::MUL_A_W-1:0]     mul_a;
    logic signed [pidc_pkg::MUL_B_W-1:0]     mul_b;
    logic signed [pidc_pkg::PROD_W-1:0]      prod_next, prod_abs;
    logic [pidc_pkg::HALF_W-1:0]             rcp_half;
    logic [pidc_pkg::RCP_PART_W-1:0]         rcp_part;
    logic [pidc_pkg::RCP_SUM_W-1:0]          rcp_sum;
    logic [pidc_pkg::DIV_W-1:0]              iquo_next;
    logic signed [pidc_pkg::DERIV_W-1:0]     diff, diff_abs, deriv_q;
    logic signed [32:0]                      integ_q;
    logic signed [ACC_W-1:0]                 acc_sum, acc_lim, acc_clamped;
    logic [pidc_pkg::ERR_W-1:0]              err_mag;
    logic signed [pidc_pkg::INTEG_W-1:0]     integ_next;
    logic signed [pidc_pkg::SUM_W-1:0]       sum_biased;
    logic signed [31:0]                      drv_full;
    logic signed [15:0]                      drv_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg      <= '0;
            integ_gain_reg     <= '0;
            deriv_gain_reg     <= '0;
            integral_limit_reg <= '0;
            error_deadband_reg <= '0;
            drive_min_reg      <= -16'sd32768;
            drive_max_reg      <= 16'sd32767;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pidc_pkg::REG_PROP_GAIN:      prop_gain_reg      <= cfg_data[15:0];
                pidc_pkg::REG_INTEG_GAIN:     integ_gain_reg     <= cfg_data[15:0];
                pidc_pkg::REG_DERIV_GAIN:     deriv_gain_reg     <= cfg_data[15:0];
                pidc_pkg::REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[19:0];
                pidc_pkg::REG_ERROR_DEADBAND: error_deadband_reg <= cfg_data[16:0];
                pidc_pkg::REG_DRIVE_MIN:      drive_min_reg      <= cfg_data[15:0];
                pidc_pkg::REG_DRIVE_MAX:      drive_max_reg      <= cfg_data[15:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.op)
            pidc_pkg::OP_MUL_ED:
            begin
                mul_a = pidc_pkg::MUL_A_W'(err_reg);
                mul_b = {1'b0, dt_reg};
            end
            pidc_pkg::OP_MUL_P:
            begin
                mul_a = pidc_pkg::MUL_A_W'(err_reg);
                mul_b = pidc_pkg::MUL_B_W'(prop_gain_reg);
            end
            pidc_pkg::OP_MUL_I:
            begin
                mul_a = integ_reg;
                mul_b = pidc_pkg::MUL_B_W'(integ_gain_reg);
            end
            default:
            begin
                mul_a = pidc_pkg::MUL_A_W'(deriv_reg);
                mul_b = pidc_pkg::MUL_B_W'(deriv_gain_reg);
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Divide |error*elapsed| by the scale: low half first, then high half and shift
    always_comb
    begin
        prod_abs  = prod_reg[pidc_pkg::PROD_W-1] ? -prod_reg : prod_reg;
        rcp_half  = (cmd.op == pidc_pkg::OP_QUO_HI) ? prod_abs[31:16] : prod_abs[15:0];
        rcp_part  = rcp_half * RCP_MUL;
        rcp_sum   = {rcp_part, {pidc_pkg::HALF_W{1'b0}}} + pidc_pkg::RCP_SUM_W'(rcp_lo_reg);
        iquo_next = pidc_pkg::DIV_W'(rcp_sum >> RCP_SHIFT);
    end

    always_comb
    begin
        diff         = pidc_pkg::DERIV_W'(err_reg) - pidc_pkg::DERIV_W'(last_reg);
        diff_abs     = diff[pidc_pkg::DERIV_W-1] ? -diff : diff;
        div_start    = (cmd.op == pidc_pkg::OP_DIV_D);
        div_dividend = pidc_pkg::DIV_W'(diff_abs[pidc_pkg::DERIV_W-2:0]);
        div_divisor  = dt_reg;
    end

    pidc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        integ_q  = neg_reg ? -$signed({1'b0, iquo_reg}) : $signed({1'b0, iquo_reg});
        deriv_q  = neg_reg ? -$signed({1'b0, div_quotient[pidc_pkg::DERIV_W-2:0]})
                           : $signed({1'b0, div_quotient[pidc_pkg::DERIV_W-2:0]});
        acc_sum  = ACC_W'(integ_reg) + ACC_W'(integ_q);
        acc_lim  = $signed({{(ACC_W-20){1'b0}}, integral_limit_reg});
        if (acc_sum > acc_lim)
            acc_clamped = acc_lim;
        else if (acc_sum < -acc_lim)
            acc_clamped = -acc_lim;
        else
            acc_clamped = acc_sum;
        err_mag    = err_reg[pidc_pkg::ERR_W-1] ? pidc_pkg::ERR_W'(-err_reg) : err_reg;
        integ_next = (err_mag < error_deadband_reg) ? '0
                                                    : acc_clamped[pidc_pkg::INTEG_W-1:0];
    end

    always_comb
    begin
        sum_biased = sum_reg + (sum_reg[pidc_pkg::SUM_W-1] ? pidc_pkg::SUM_W'(255)
                                                          : pidc_pkg::SUM_W'(0));
        drv_full   = sum_biased[pidc_pkg::SUM_W-1:8];
        if (drv_full > 32'(drive_max_reg))
            drv_clamped = drive_max_reg;
        else if (drv_full < 32'(drive_min_reg))
            drv_clamped = drive_min_reg;
        else
            drv_clamped = drv_full[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                pidc_pkg::OP_CLEAR:
                begin
                    integ_reg <= '0;
                    last_reg  <= '0;
                end
                pidc_pkg::OP_ACC:   integ_reg <= integ_next;
                pidc_pkg::OP_DERIV: last_reg  <= err_reg;
                default:            ;
            endcase
            if (cmd.op == pidc_pkg::OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            pidc_pkg::OP_LOAD:
            begin
                err_reg   <= pidc_pkg::ERR_W'(target) - pidc_pkg::ERR_W'(measurement);
                dt_reg    <= elapsed;
                zflag_reg <= (elapsed == '0);
                clr_reg   <= 1'b0;
            end
            pidc_pkg::OP_CLEAR:
            begin
                zflag_reg <= 1'b0;
                clr_reg   <= 1'b1;
            end
            pidc_pkg::OP_MUL_ED:
            begin
                prod_reg <= prod_next;
            end
            pidc_pkg::OP_QUO_LO:
            begin
                rcp_lo_reg <= rcp_part;
                neg_reg    <= prod_reg[pidc_pkg::PROD_W-1];
            end
            pidc_pkg::OP_QUO_HI:
            begin
                iquo_reg <= iquo_next;
            end
            pidc_pkg::OP_DIV_D:
            begin
                neg_reg <= diff[pidc_pkg::DERIV_W-1];
            end
            pidc_pkg::OP_DERIV:
            begin
                deriv_reg <= zflag_reg ? '0 : deriv_q;
            end
            pidc_pkg::OP_MUL_P:
            begin
                prod_reg <= prod_next;
            end
            pidc_pkg::OP_MUL_I:
            begin
                prod_reg <= prod_next;
                sum_reg  <= pidc_pkg::SUM_W'(prod_reg);
            end
            pidc_pkg::OP_MUL_D:
            begin
                prod_reg <= prod_next;
                sum_reg  <= sum_reg + pidc_pkg::SUM_W'(prod_reg);
            end
            pidc_pkg::OP_SUM_D:
            begin
                sum_reg <= sum_reg + pidc_pkg::SUM_W'(prod_reg);
            end
            pidc_pkg::OP_OUT:
            begin
                drive_reg <= clr_reg ? 16'sd0 : drv_clamped;
                ezero_reg <= zflag_reg;
            end
            default: ;
        endcase
    end

    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign drive         = drive_reg;
    assign elapsed_zero  = ezero_reg;

endmodule

// ===== rtl/pidc_ctrl.sv =====
module pidc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_clear,
    input  pidc_pkg::stat_t   stat,
    output pidc_pkg::cmd_t    cmd
);

    pidc_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pidc_pkg::ST_IDLE:
                if (in_valid)
                    state_next = in_clear ? pidc_pkg::ST_DONE : pidc_pkg::ST_MUL_ED;
            pidc_pkg::ST_MUL_ED: state_next = pidc_pkg::ST_QUO_LO;
            pidc_pkg::ST_QUO_LO: state_next = pidc_pkg::ST_QUO_HI;
            pidc_pkg::ST_QUO_HI: state_next = pidc_pkg::ST_ACC;
            pidc_pkg::ST_ACC:    state_next = pidc_pkg::ST_DIV_D;
            pidc_pkg::ST_DIV_D:  state_next = pidc_pkg::ST_WAIT_D;
            pidc_pkg::ST_WAIT_D:
                if (stat.div_done)
                    state_next = pidc_pkg::ST_MUL_P;
            pidc_pkg::ST_MUL_P:  state_next = pidc_pkg::ST_MUL_I;
            pidc_pkg::ST_MUL_I:  state_next = pidc_pkg::ST_MUL_D;
            pidc_pkg::ST_MUL_D:  state_next = pidc_pkg::ST_SUM_D;
            pidc_pkg::ST_SUM_D:  state_next = pidc_pkg::ST_DONE;
            pidc_pkg::ST_DONE:
                if (stat.out_free)
                    state_next = pidc_pkg::ST_IDLE;
            default:             state_next = pidc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = pidc_pkg::OP_NONE;
        unique case (state_reg)
            pidc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = in_clear ? pidc_pkg::OP_CLEAR : pidc_pkg::OP_LOAD;
            end
            pidc_pkg::ST_MUL_ED: cmd.op = pidc_pkg::OP_MUL_ED;
            pidc_pkg::ST_QUO_LO: cmd.op = pidc_pkg::OP_QUO_LO;
            pidc_pkg::ST_QUO_HI: cmd.op = pidc_pkg::OP_QUO_HI;
            pidc_pkg::ST_ACC:    cmd.op = pidc_pkg::OP_ACC;
            pidc_pkg::ST_DIV_D:  cmd.op = pidc_pkg::OP_DIV_D;
            pidc_pkg::ST_WAIT_D:
                if (stat.div_done)
                    cmd.op = pidc_pkg::OP_DERIV;
            pidc_pkg::ST_MUL_P:  cmd.op = pidc_pkg::OP_MUL_P;
            pidc_pkg::ST_MUL_I:  cmd.op = pidc_pkg::OP_MUL_I;
            pidc_pkg::ST_MUL_D:  cmd.op = pidc_pkg::OP_MUL_D;
            pidc_pkg::ST_SUM_D:  cmd.op = pidc_pkg::OP_SUM_D;
            pidc_pkg::ST_DONE:
                if (stat.out_free)
                    cmd.op = pidc_pkg::OP_OUT;
            default:             cmd.op = pidc_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pidc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
